@@ hdl/brc_pkg.sv @@
package brc_pkg;

   localparam int BAND_W     = 20;
   localparam int COEF_W     = 24;
   localparam int LIM_W      = 24;
   localparam int CHL_W      = 32;
   localparam int MODE_W     = 2;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int NUM_COEF   = 5;

   // ratio datapath
   localparam int DIV_W      = 19;               // positive 20-bit band
   localparam int QUO_W      = DIV_W + 16;       // num * 2^16 / den
   localparam int RATIO_W    = 24;
   localparam int FRAC_BITS  = 20;
   localparam int MANT_W     = 31;               // Q30 mantissa in [1,2)
   localparam int LOG_W      = 26;
   localparam int L_W        = 24;
   localparam int POLY_W     = 36;
   localparam int PSAT_W     = 26;
   localparam int EXP_W      = 29;
   localparam int POW_V_W    = 32;
   localparam int CODE_W     = 33;

   localparam logic signed [30:0] LOG10_2_Q30 = 31'sd323228497;
   localparam logic signed [30:0] LOG2_10_Q28 = 31'sd891723283;
   localparam int NEG_LIMIT = -1048;

   localparam logic [CODE_W-1:0] CHL_MIN_CODE = 33'd66;
   localparam logic [CODE_W-1:0] CHL_MAX_CODE = 33'd6553600;

   localparam logic [MODE_W-1:0] MODE_TWO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_THREE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FOUR  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAND  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF3      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF4      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_HIGH = 3'd7;

   typedef logic [COEF_W-1:0] coef_type;

   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
   } ctl_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_arg;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-k) in Q30, each root taken from the previous one
   function automatic logic [31:0] pow_root(input int k);
      logic [63:0] t;
      t = 64'd1 << 31;
      for (int i = 1; i <= k; i++)
         t = isqrt64(t << 30);
      return t[31:0];
   endfunction

endpackage

@@ hdl/brc_front.sv @@
module brc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic signed [brc_pkg::BAND_W-1:0]   band_a,
   input  logic signed [brc_pkg::BAND_W-1:0]   band_b,
   input  logic signed [brc_pkg::BAND_W-1:0]   band_c,
   input  logic signed [brc_pkg::BAND_W-1:0]   band_d,
   input  logic        [brc_pkg::MODE_W-1:0]   mode,
   output brc_pkg::ctl_type                    ctl_ff,
   output logic        [brc_pkg::DIV_W-1:0]    num_ff,
   output logic        [brc_pkg::DIV_W-1:0]    den_ff
);
   import brc_pkg::*;

   logic signed [BAND_W-1:0] mn, mx_ab, mx_abc, num, den;
   logic signed [23:0]       b_ext, b_x10, a_ext;
   logic                     ok, good;
   ctl_type                  ctl_in;
   logic [DIV_W-1:0]         num_in, den_in;

   always_comb begin
      mn     = (band_a < band_b) ? band_a : band_b;
      mx_ab  = (band_a > band_b) ? band_a : band_b;
      mx_abc = (band_c > mx_ab) ? band_c : mx_ab;
      b_ext  = 24'(band_b);
      a_ext  = 24'(band_a);
      b_x10  = (b_ext <<< 3) + (b_ext <<< 1);
      case (mode)
         MODE_TWO: begin
            ok  = band_a > 0 && band_b > 0 && a_ext <= b_x10;
            num = band_a;
            den = band_b;
         end
         MODE_THREE: begin
            ok  = band_c > 0 && band_b > 0 && mn >= NEG_LIMIT;
            num = mx_ab;
            den = band_c;
         end
         default: begin
            ok  = band_d > 0 && band_c > 0 && (band_b > 0 || (band_a < 0 && band_b < 0))
                  && mn >= NEG_LIMIT;
            num = mx_abc;
            den = band_d;
         end
      endcase
      good          = ok && num > 0 && den > 0;
      num_in        = good ? num[DIV_W-1:0] : DIV_W'(1);
      den_in        = good ? den[DIV_W-1:0] : DIV_W'(1);
      ctl_in.valid  = in_valid;
      ctl_in.status = good ? STAT_OK : STAT_BAND;
   end

   always_ff @(posedge clock) begin
      if (reset) ctl_ff.valid <= 1'b0;
      else if (advance) ctl_ff <= ctl_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

endmodule

@@ hdl/brc_div.sv @@
module brc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  brc_pkg::ctl_type                   ctl,
   input  logic [brc_pkg::DIV_W-1:0]          num,
   input  logic [brc_pkg::DIV_W-1:0]          den,
   input  logic [brc_pkg::LIM_W-1:0]          ratio_low,
   input  logic [brc_pkg::LIM_W-1:0]          ratio_high,
   output brc_pkg::ctl_type                   ctl_out_ff,
   output logic [brc_pkg::RATIO_W-1:0]        ratio_ff
);
   import brc_pkg::*;

   localparam int STAGES = QUO_W;

   ctl_type          ctl_ff [STAGES];
   logic [DIV_W-1:0] rem_ff [STAGES];
   logic [DIV_W-1:0] den_ff [STAGES];
   logic [QUO_W-1:0] qd_ff  [STAGES];

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < STAGES; s++) begin : g_div
      ctl_type          ctl_p;
      logic [DIV_W-1:0] rem_p, den_p;
      logic [QUO_W-1:0] qd_p;
      logic [DIV_W:0]   trial;
      logic             take;

      if (s == 0) begin : g_first
         assign ctl_p = ctl;
         assign rem_p = '0;
         assign den_p = den;
         assign qd_p  = {num, 16'b0};
      end else begin : g_next
         assign ctl_p = ctl_ff[s-1];
         assign rem_p = rem_ff[s-1];
         assign den_p = den_ff[s-1];
         assign qd_p  = qd_ff[s-1];
      end

      assign trial = {rem_p, qd_p[QUO_W-1]};
      assign take  = trial >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (reset) ctl_ff[s].valid <= 1'b0;
         else if (advance) ctl_ff[s] <= ctl_p;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= take ? DIV_W'(trial - {1'b0, den_p}) : trial[DIV_W-1:0];
            den_ff[s] <= den_p;
            qd_ff[s]  <= {qd_p[QUO_W-2:0], take};
         end
      end
   end

   logic [QUO_W-1:0] quo;
   logic             in_range;
   ctl_type          ctl_out_in;

   always_comb begin
      quo        = qd_ff[STAGES-1];
      in_range   = quo > QUO_W'(ratio_low) && quo < QUO_W'(ratio_high);
      ctl_out_in = ctl_ff[STAGES-1];
      if (ctl_out_in.status == STAT_OK && !in_range) ctl_out_in.status = STAT_RANGE;
   end

   always_ff @(posedge clock) begin
      if (reset) ctl_out_ff.valid <= 1'b0;
      else if (advance) ctl_out_ff <= ctl_out_in;
   end

   always_ff @(posedge clock) begin
      if (advance) ratio_ff <= quo[RATIO_W-1:0];
   end

endmodule

@@ hdl/brc_log.sv @@
module brc_log (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  brc_pkg::ctl_type                  ctl,
   input  logic [brc_pkg::RATIO_W-1:0]       ratio,
   output brc_pkg::ctl_type                  ctl_out_ff,
   output logic signed [brc_pkg::L_W-1:0]    log10_ratio
);
   import brc_pkg::*;

   localparam int K_W = $clog2(RATIO_W);

   // normalize
   logic [K_W-1:0]    k_in;
   logic [MANT_W-1:0] m_in;
   ctl_type           ctl0_ff;
   logic [K_W-1:0]    k0_ff;
   logic [MANT_W-1:0] m0_ff;

   always_comb begin
      k_in = '0;
      for (int i = 0; i < RATIO_W; i++)
         if (ratio[i]) k_in = K_W'(i);
      m_in = MANT_W'(MANT_W'(ratio) << (K_W'(MANT_W - 1) - k_in));
   end

   always_ff @(posedge clock) begin
      if (reset) ctl0_ff.valid <= 1'b0;
      else if (advance) ctl0_ff <= ctl;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k0_ff <= k_in;
         m0_ff <= m_in;
      end
   end

   // one fraction bit per squaring stage
   ctl_type              ctl_ff  [FRAC_BITS];
   logic [K_W-1:0]       k_ff    [FRAC_BITS];
   logic [MANT_W-1:0]    m_ff    [FRAC_BITS];
   logic [FRAC_BITS-1:0] frac_ff [FRAC_BITS];

   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_sq
      ctl_type              ctl_p;
      logic [K_W-1:0]       k_p;
      logic [MANT_W-1:0]    m_p;
      logic [FRAC_BITS-1:0] frac_p;
      logic [2*MANT_W-1:0]  prod;
      logic [MANT_W:0]      sq;

      if (s == 0) begin : g_first
         assign ctl_p  = ctl0_ff;
         assign k_p    = k0_ff;
         assign m_p    = m0_ff;
         assign frac_p = '0;
      end else begin : g_next
         assign ctl_p  = ctl_ff[s-1];
         assign k_p    = k_ff[s-1];
         assign m_p    = m_ff[s-1];
         assign frac_p = frac_ff[s-1];
      end

      assign prod = (2*MANT_W)'(m_p) * (2*MANT_W)'(m_p);
      assign sq   = prod[2*MANT_W-1:MANT_W-1];

      always_ff @(posedge clock) begin
         if (reset) ctl_ff[s].valid <= 1'b0;
         else if (advance) ctl_ff[s] <= ctl_p;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            k_ff[s]    <= k_p;
            m_ff[s]    <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
            frac_ff[s] <= {frac_p[FRAC_BITS-2:0], sq[MANT_W]};
         end
      end
   end

   // log2 minus the 2^-16 ratio scale, then times log10(2)
   ctl_type                 ctl_lg_ff, ctl_pr_ff;
   logic signed [LOG_W-1:0] lg_in, lg_ff;
   logic signed [LOG_W+30:0] prod_ff;

   assign lg_in = $signed({1'b0, k_ff[FRAC_BITS-1], frac_ff[FRAC_BITS-1]})
                  - LOG_W'(16 << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_lg_ff.valid <= 1'b0;
         ctl_pr_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_lg_ff <= ctl_ff[FRAC_BITS-1];
         ctl_pr_ff <= ctl_lg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lg_ff   <= lg_in;
         prod_ff <= (LOG_W+31)'(lg_ff) * (LOG_W+31)'(LOG10_2_Q30);
      end
   end

   assign ctl_out_ff  = ctl_pr_ff;
   assign log10_ratio = prod_ff[L_W+29:30];

endmodule

@@ hdl/brc_poly.sv @@
module brc_poly (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          advance,
   input  brc_pkg::ctl_type                              ctl,
   input  logic signed [brc_pkg::L_W-1:0]                log10_ratio,
   input  brc_pkg::coef_type [brc_pkg::NUM_COEF-1:0]     coefs,
   output brc_pkg::ctl_type                              ctl_out_ff,
   output logic signed [brc_pkg::PSAT_W+30:0]            exp_prod_ff
);
   import brc_pkg::*;

   localparam int STEPS  = NUM_COEF - 1;
   localparam int PROD_W = L_W + POLY_W;

   ctl_type                  ctl_m_ff [STEPS];
   logic signed [L_W-1:0]    l_m_ff   [STEPS];
   logic signed [PROD_W-1:0] prod_ff  [STEPS];
   ctl_type                  ctl_a_ff [STEPS];
   logic signed [L_W-1:0]    l_a_ff   [STEPS];
   logic signed [POLY_W-1:0] p_ff     [STEPS];

   // Horner: multiply stage, then add stage
   for (genvar j = 0; j < STEPS; j++) begin : g_horner
      ctl_type                  ctl_p;
      logic signed [L_W-1:0]    l_p;
      logic signed [POLY_W-1:0] p_p;
      logic signed [COEF_W-1:0] c_add;

      if (j == 0) begin : g_first
         assign ctl_p = ctl;
         assign l_p   = log10_ratio;
         assign p_p   = POLY_W'($signed(coefs[NUM_COEF-1]));
      end else begin : g_next
         assign ctl_p = ctl_a_ff[j-1];
         assign l_p   = l_a_ff[j-1];
         assign p_p   = p_ff[j-1];
      end

      assign c_add = $signed(coefs[NUM_COEF-2-j]);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_m_ff[j].valid <= 1'b0;
            ctl_a_ff[j].valid <= 1'b0;
         end else if (advance) begin
            ctl_m_ff[j] <= ctl_p;
            ctl_a_ff[j] <= ctl_m_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            l_m_ff[j]  <= l_p;
            prod_ff[j] <= PROD_W'(l_p) * PROD_W'(p_p);
            l_a_ff[j]  <= l_m_ff[j];
            p_ff[j]    <= POLY_W'(c_add) + prod_ff[j][POLY_W+FRAC_BITS-1:FRAC_BITS];
         end
      end
   end

   // saturate to +/-16, then scale by log2(10)
   localparam logic signed [POLY_W-1:0] P_LIM = POLY_W'(16 << FRAC_BITS);

   ctl_type                   ctl_s_ff;
   logic signed [PSAT_W-1:0]  psat_ff;
   logic signed [POLY_W-1:0]  p_fin;
   logic signed [PSAT_W-1:0]  psat_in;

   always_comb begin
      p_fin = p_ff[STEPS-1];
      if (p_fin > P_LIM) psat_in = PSAT_W'(P_LIM);
      else if (p_fin < -P_LIM) psat_in = PSAT_W'(-P_LIM);
      else psat_in = p_fin[PSAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s_ff.valid   <= 1'b0;
         ctl_out_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_s_ff   <= ctl_a_ff[STEPS-1];
         ctl_out_ff <= ctl_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         psat_ff     <= psat_in;
         exp_prod_ff <= (PSAT_W+31)'(psat_ff) * (PSAT_W+31)'(LOG2_10_Q28);
      end
   end

endmodule

@@ hdl/brc_pow.sv @@
module brc_pow (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  brc_pkg::ctl_type                    ctl,
   input  logic signed [brc_pkg::PSAT_W+30:0]  exp_prod,
   output logic                                rsp_valid_ff,
   output logic [brc_pkg::CHL_W-1:0]           rsp_chlorophyll_ff,
   output logic [brc_pkg::STAT_W-1:0]          rsp_status_ff
);
   import brc_pkg::*;

   localparam int N_W = 5;

   // split exponent
   logic signed [EXP_W-1:0] e_in;
   ctl_type                 ctl_e_ff;
   logic                    lo_ff, hi_ff;
   logic [N_W-1:0]          n_ff;
   logic [FRAC_BITS-1:0]    f_ff;

   assign e_in = exp_prod[EXP_W+27:28] + EXP_W'(16 << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) ctl_e_ff.valid <= 1'b0;
      else if (advance) ctl_e_ff <= ctl;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff <= e_in[EXP_W-1];
         hi_ff <= !e_in[EXP_W-1] && e_in >= EXP_W'(32 << FRAC_BITS);
         n_ff  <= e_in[FRAC_BITS+N_W-1:FRAC_BITS];
         f_ff  <= e_in[FRAC_BITS-1:0];
      end
   end

   // 2^frac, one root multiply per fraction bit
   ctl_type              ctl_ff [FRAC_BITS];
   logic                 lo_s_ff [FRAC_BITS];
   logic                 hi_s_ff [FRAC_BITS];
   logic [N_W-1:0]       n_s_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] f_s_ff [FRAC_BITS];
   logic [POW_V_W-1:0]   v_ff   [FRAC_BITS];

   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_pow
      localparam logic [POW_V_W-1:0] ROOT = pow_root(s + 1);

      ctl_type              ctl_p;
      logic                 lo_p, hi_p;
      logic [N_W-1:0]       n_p;
      logic [FRAC_BITS-1:0] f_p;
      logic [POW_V_W-1:0]   v_p;
      logic [2*POW_V_W-1:0] prod;

      if (s == 0) begin : g_first
         assign ctl_p = ctl_e_ff;
         assign lo_p  = lo_ff;
         assign hi_p  = hi_ff;
         assign n_p   = n_ff;
         assign f_p   = f_ff;
         assign v_p   = POW_V_W'(1) << 30;
      end else begin : g_next
         assign ctl_p = ctl_ff[s-1];
         assign lo_p  = lo_s_ff[s-1];
         assign hi_p  = hi_s_ff[s-1];
         assign n_p   = n_s_ff[s-1];
         assign f_p   = f_s_ff[s-1];
         assign v_p   = v_ff[s-1];
      end

      assign prod = (2*POW_V_W)'(v_p) * (2*POW_V_W)'(ROOT);

      always_ff @(posedge clock) begin
         if (reset) ctl_ff[s].valid <= 1'b0;
         else if (advance) ctl_ff[s] <= ctl_p;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            lo_s_ff[s] <= lo_p;
            hi_s_ff[s] <= hi_p;
            n_s_ff[s]  <= n_p;
            f_s_ff[s]  <= f_p;
            v_ff[s]    <= f_p[FRAC_BITS-1-s] ? prod[POW_V_W+29:30] : v_p;
         end
      end
   end

   // apply integer exponent
   ctl_type             ctl_c_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [63:0]         shifted;
   logic [CODE_W-1:0]   code_in;

   always_comb begin
      shifted = 64'(v_ff[FRAC_BITS-1]) << n_s_ff[FRAC_BITS-1];
      if (lo_s_ff[FRAC_BITS-1]) code_in = '0;
      else if (hi_s_ff[FRAC_BITS-1]) code_in = CODE_W'(1) << 32;
      else code_in = shifted[CODE_W+29:30];
   end

   always_ff @(posedge clock) begin
      if (reset) ctl_c_ff.valid <= 1'b0;
      else if (advance) ctl_c_ff <= ctl_ff[FRAC_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (advance) code_ff <= code_in;
   end

   // clamp into the output register
   logic [CODE_W-1:0] clamped;

   always_comb begin
      clamped = (code_ff < CHL_MIN_CODE) ? CHL_MIN_CODE : code_ff;
      if (clamped > CHL_MAX_CODE) clamped = CHL_MAX_CODE;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= ctl_c_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff      <= ctl_c_ff.status;
         rsp_chlorophyll_ff <= (ctl_c_ff.status == STAT_OK) ? clamped[CHL_W-1:0] : '0;
      end
   end

endmodule

@@ hdl/band_ratio_chlorophyll.sv @@
// Throughput: one pixel per cycle; the 35-stage divider, 20 log squaring stages,
// Horner multiply/add pairs and 20 root-multiply stages all advance together.
// Stall: the whole pipeline holds while the output register waits for rsp_ready.
// Reset: synchronous, active high; clears all stage valids and loads the
// register defaults (mode four-band, coefficients zero, ratio limits 13107/1966080).
module band_ratio_chlorophyll (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [brc_pkg::BAND_W-1:0]   req_band_a,
   input  logic signed [brc_pkg::BAND_W-1:0]   req_band_b,
   input  logic signed [brc_pkg::BAND_W-1:0]   req_band_c,
   input  logic signed [brc_pkg::BAND_W-1:0]   req_band_d,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [brc_pkg::CHL_W-1:0]           rsp_chlorophyll,
   output logic [brc_pkg::STAT_W-1:0]          rsp_status,
   input  logic                                csr_write_en,
   input  logic [brc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [brc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import brc_pkg::*;

   logic [MODE_W-1:0]            mode_ff;
   coef_type [NUM_COEF-1:0]      coef_ff;
   logic [LIM_W-1:0]             ratio_low_ff, ratio_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_FOUR;
         coef_ff       <= '0;
         ratio_low_ff  <= LIM_W'(13107);
         ratio_high_ff <= LIM_W'(1966080);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_MODE:       mode_ff       <= csr_data[MODE_W-1:0];
            REG_COEF0:      coef_ff[0]    <= csr_data;
            REG_COEF1:      coef_ff[1]    <= csr_data;
            REG_COEF2:      coef_ff[2]    <= csr_data;
            REG_COEF3:      coef_ff[3]    <= csr_data;
            REG_COEF4:      coef_ff[4]    <= csr_data;
            REG_RATIO_LOW:  ratio_low_ff  <= csr_data;
            REG_RATIO_HIGH: ratio_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   ctl_type                     ctl_front, ctl_div, ctl_log, ctl_poly;
   logic [DIV_W-1:0]            num, den;
   logic [RATIO_W-1:0]          ratio;
   logic signed [L_W-1:0]       log10_ratio;
   logic signed [PSAT_W+30:0]   exp_prod;

   brc_front u_front (
      .clock, .reset, .advance,
      .in_valid (req_valid),
      .band_a   (req_band_a),
      .band_b   (req_band_b),
      .band_c   (req_band_c),
      .band_d   (req_band_d),
      .mode     (mode_ff),
      .ctl_ff   (ctl_front),
      .num_ff   (num),
      .den_ff   (den)
   );

   brc_div u_div (
      .clock, .reset, .advance,
      .ctl        (ctl_front),
      .num, .den,
      .ratio_low  (ratio_low_ff),
      .ratio_high (ratio_high_ff),
      .ctl_out_ff (ctl_div),
      .ratio_ff   (ratio)
   );

   brc_log u_log (
      .clock, .reset, .advance,
      .ctl         (ctl_div),
      .ratio,
      .ctl_out_ff  (ctl_log),
      .log10_ratio
   );

   brc_poly u_poly (
      .clock, .reset, .advance,
      .ctl         (ctl_log),
      .log10_ratio,
      .coefs       (coef_ff),
      .ctl_out_ff  (ctl_poly),
      .exp_prod_ff (exp_prod)
   );

   brc_pow u_pow (
      .clock, .reset, .advance,
      .ctl                (ctl_poly),
      .exp_prod,
      .rsp_valid_ff       (rsp_valid),
      .rsp_chlorophyll_ff (rsp_chlorophyll),
      .rsp_status_ff      (rsp_status)
   );

endmodule
